@@ src/stq_pkg.sv @@
// Shared types and constants for the sorted timeout timer queue.
// No dependencies; used by stq_cell and sorted_timeout_timer_queue_core.
package stq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int SLOT_W     = 4;
   localparam int DL_W       = 32;
   localparam int MAX_OUT    = 16;
   localparam int CNT_W      = $clog2(MAX_OUT + 1);

   typedef enum logic [2:0] {
      ACT_ALLOC = 3'd0,
      ACT_FREE  = 3'd1,
      ACT_BIND  = 3'd2,
      ACT_START = 3'd3,
      ACT_TICK  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_WRONG   = 2'd2,
      ST_EXPIRED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_ALLOC = 2'd1,
      SLOT_RUN   = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_cmd_type;

   typedef enum logic {
      FSM_IDLE   = 1'b0,
      FSM_EXPIRE = 1'b1
   } fsm_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [DL_W-1:0]   dl;
   } entry_type;

endpackage

@@ src/sorted_timeout_timer_queue_core.sv @@
// Timer pool with a chain of cells that keeps running timers in deadline order.
// Allocate, free, bind and start give their beat from the result register in the cycle after accept.
// A tick blocks requests while due timers expire, one beat each; the first beat comes
// from the expiry state after the tick is accepted; a tick gives at most 16 beats.
// One request per cycle when not stalled, except ticks; the chain inserts in parallel.
// Reset clears slot states, the chain, the tick count and the result valid bit.
// Depends on stq_pkg and stq_cell.
module sorted_timeout_timer_queue_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic [stq_pkg::SLOT_W-1:0]    req_slot,
   input  logic [31:0]                   req_timeout,
   input  logic [31:0]                   req_data,
   input  logic [2:0]                    req_queue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [stq_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [2:0]                    rsp_queue_out,
   output logic [31:0]                   rsp_data_out,
   output logic                          rsp_last
);
   import stq_pkg::*;

   fsm_type                fsm_ff, fsm_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DL_W-1:0]        tick_ff, tick_in;
   slot_state_type         sst_ff [NUM_TIMERS];
   slot_state_type         sst_in [NUM_TIMERS];
   logic [31:0]            pay_ff [NUM_TIMERS];
   logic [2:0]             que_ff [NUM_TIMERS];
   logic                   bind_we;

   logic                   rv_ff, rv_in;
   status_type             rs_ff, rs_in;
   logic [SLOT_W-1:0]      rslot_ff, rslot_in;
   logic [2:0]             rq_ff, rq_in;
   logic [31:0]            rd_ff, rd_in;
   logic                   rl_ff, rl_in;

   cell_cmd_type           cmd;
   entry_type              new_ent;
   entry_type              ents [NUM_TIMERS];
   logic                   keeps [NUM_TIMERS];

   logic                   out_free, acc, in_range, found, due0, due1;
   logic [SLOT_W-1:0]      free_idx;

   assign out_free  = !rv_ff || !rsp_stall;
   assign req_stall = !(fsm_ff == FSM_IDLE && out_free);
   assign acc       = req_valid && !req_stall;
   assign in_range  = {1'b0, req_slot} < (SLOT_W + 1)'(NUM_TIMERS);
   assign new_ent   = '{valid: 1'b1, slot: req_slot, dl: req_timeout + tick_ff};

   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (sst_ff[i] == SLOT_FREE) begin
            found    = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign due0 = ents[0].valid && (ents[0].dl <= tick_ff) && (cnt_ff < CNT_W'(MAX_OUT));
   assign due1 = ents[1].valid && (ents[1].dl <= tick_ff) &&
                 (cnt_ff + CNT_W'(1) < CNT_W'(MAX_OUT));

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      stq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_ent  ((g == 0) ? entry_type'('0) : ents[(g == 0) ? 0 : g - 1]),
         .next_ent  ((g == NUM_TIMERS - 1) ? entry_type'('0)
                                           : ents[(g == NUM_TIMERS - 1) ? g : g + 1]),
         .new_ent   (new_ent),
         .prev_keep ((g == 0) ? 1'b1 : keeps[(g == 0) ? 0 : g - 1]),
         .ent       (ents[g]),
         .keep      (keeps[g])
      );
   end

   always_comb begin
      fsm_in   = fsm_ff;
      cnt_in   = cnt_ff;
      tick_in  = tick_ff;
      sst_in   = sst_ff;
      bind_we  = 1'b0;
      cmd      = CELL_HOLD;
      rv_in    = rv_ff && rsp_stall;
      rs_in    = rs_ff;
      rslot_in = rslot_ff;
      rq_in    = rq_ff;
      rd_in    = rd_ff;
      rl_in    = rl_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (acc) begin
               rv_in    = 1'b1;
               rs_in    = ST_DONE;
               rslot_in = req_slot;
               rq_in    = '0;
               rd_in    = '0;
               rl_in    = 1'b1;
               case (req_action)
                  ACT_ALLOC: begin
                     if (found) begin
                        sst_in[free_idx] = SLOT_ALLOC;
                        rslot_in         = free_idx;
                     end else begin
                        rs_in    = ST_NOFREE;
                        rslot_in = '0;
                     end
                  end
                  ACT_TICK: begin
                     rv_in   = 1'b0;
                     tick_in = tick_ff + DL_W'(1);
                     cnt_in  = '0;
                     fsm_in  = FSM_EXPIRE;
                  end
                  ACT_FREE: begin
                     if (!in_range || sst_ff[req_slot] == SLOT_RUN) begin
                        rs_in = ST_WRONG;
                     end else begin
                        sst_in[req_slot] = SLOT_FREE;
                     end
                  end
                  ACT_BIND: begin
                     if (!in_range) begin
                        rs_in = ST_WRONG;
                     end else begin
                        bind_we = 1'b1;
                     end
                  end
                  ACT_START: begin
                     if (!in_range || sst_ff[req_slot] != SLOT_ALLOC) begin
                        rs_in = ST_WRONG;
                     end else begin
                        sst_in[req_slot] = SLOT_RUN;
                        cmd              = CELL_INSERT;
                     end
                  end
                  default: begin
                     rs_in    = ST_WRONG;
                     rslot_in = '0;
                  end
               endcase
            end
         end
         FSM_EXPIRE: begin
            if (!due0) begin
               fsm_in = FSM_IDLE;
            end else if (out_free) begin
               rv_in              = 1'b1;
               rs_in              = ST_EXPIRED;
               rslot_in           = ents[0].slot;
               rq_in              = que_ff[ents[0].slot];
               rd_in              = pay_ff[ents[0].slot];
               rl_in              = !due1;
               sst_in[ents[0].slot] = SLOT_ALLOC;
               cmd                = CELL_SHIFT;
               cnt_in             = cnt_ff + CNT_W'(1);
               if (!due1) begin
                  fsm_in = FSM_IDLE;
               end
            end
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff  <= FSM_IDLE;
         cnt_ff  <= '0;
         tick_ff <= '0;
         rv_ff   <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            sst_ff[i] <= SLOT_FREE;
         end
      end else begin
         fsm_ff  <= fsm_in;
         cnt_ff  <= cnt_in;
         tick_ff <= tick_in;
         rv_ff   <= rv_in;
         sst_ff  <= sst_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff    <= rs_in;
      rslot_ff <= rslot_in;
      rq_ff    <= rq_in;
      rd_ff    <= rd_in;
      rl_ff    <= rl_in;
      if (bind_we) begin
         pay_ff[req_slot] <= req_data;
         que_ff[req_slot] <= req_queue;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_status    = rs_ff;
   assign rsp_slot_out  = rslot_ff;
   assign rsp_queue_out = rq_ff;
   assign rsp_data_out  = rd_ff;
   assign rsp_last      = rl_ff;

`ifndef SYNTHESIS
   a_head_running: assert property (@(posedge clock) disable iff (reset)
      ents[0].valid |-> sst_ff[ents[0].slot] == SLOT_RUN)
      else $error("Head of the chain is not a running slot.");
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      ents[1].valid |-> ents[0].valid)
      else $error("Chain has a gap at its head.");
   a_expire_stalls: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_EXPIRE |-> req_stall)
      else $error("Request accepted while expiring.");
`endif

endmodule

@@ src/stq_cell.sv @@
// One cell of the deadline-ordered chain: holds one running timer entry.
// Depends on stq_pkg.
module stq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  stq_pkg::cell_cmd_type cmd,
   input  stq_pkg::entry_type   prev_ent,
   input  stq_pkg::entry_type   next_ent,
   input  stq_pkg::entry_type   new_ent,
   input  logic                 prev_keep,
   output stq_pkg::entry_type   ent,
   output logic                 keep
);
   import stq_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;

   assign ent  = ent_ff;
   assign keep = ent_ff.valid && (ent_ff.dl < new_ent.dl);

   always_comb begin
      ent_in = ent_ff;
      case (cmd)
         CELL_INSERT: begin
            if (!keep) begin
               ent_in = prev_keep ? new_ent : prev_ent;
            end
         end
         CELL_SHIFT: ent_in = next_ent;
         default:    ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff.slot <= ent_in.slot;
      ent_ff.dl   <= ent_in.dl;
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
   end

endmodule
